### hw/rtl/sector_cache_fifo_replace_core_macros.svh
// assertion macros used by the checker
`ifndef SECTOR_CACHE_FIFO_REPLACE_CORE_MACROS_SVH
`define SECTOR_CACHE_FIFO_REPLACE_CORE_MACROS_SVH

// same-cycle implication
`define SCFR_ASSERT_NOW(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scfr check failed");

// next-cycle implication
`define SCFR_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scfr check failed");

`endif

### hw/rtl/scfr_pkg.sv
package scfr_pkg;

    localparam int OP_W     = 3;
    localparam int ADDR_W   = 32;
    localparam int SEL_W    = 2;
    localparam int OFFSET_W = 9;
    localparam int DATA_W   = 8;
    localparam int IDX_W    = 2;

    localparam int LINES_DEF       = 4;
    localparam int BLOCK_BYTES_DEF = 512;

    localparam logic [OP_W-1:0] OP_LOOKUP     = 3'd0;
    localparam logic [OP_W-1:0] OP_FILL_BYTE  = 3'd1;
    localparam logic [OP_W-1:0] OP_FILL_DONE  = 3'd2;
    localparam logic [OP_W-1:0] OP_READ_BYTE  = 3'd3;
    localparam logic [OP_W-1:0] OP_INVALIDATE = 3'd4;

endpackage

### hw/rtl/sector_cache_fifo_replace_core.sv
// path: s1 stage registers, then output registers; an output stall holds a result
// throughput: one request per cycle unless output stalls; the sector ram is read at
//   accept and the tag registers are updated as the request leaves the lookup stage
// reset: tags, valid bits and replacement pointer clear asynchronously on rst_n low;
//   sector ram contents are not reset, no clearing pass
module sector_cache_fifo_replace_core
    import scfr_pkg::*;
#(
    parameter int LINES       = LINES_DEF,
    parameter int BLOCK_BYTES = BLOCK_BYTES_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [OP_W-1:0]     operation,
    input  logic [ADDR_W-1:0]   block_address,
    input  logic [SEL_W-1:0]    line_select,
    input  logic [OFFSET_W-1:0] byte_offset,
    input  logic [DATA_W-1:0]   fill_byte,
    input  logic                fill_ok,
    output logic                out_valid,
    input  logic                out_stall,
    output logic                hit,
    output logic [IDX_W-1:0]    line_index,
    output logic [DATA_W-1:0]   read_byte
);

    localparam int LINE_W    = (LINES > 1) ? $clog2(LINES) : 1;
    localparam int OFF_W     = $clog2(BLOCK_BYTES);
    localparam int MEM_AW    = LINE_W + OFF_W;
    localparam int MEM_DEPTH = 1 << MEM_AW;

    logic [DATA_W-1:0] sector_mem [MEM_DEPTH];

    logic                 s1_valid_reg, s1_valid_next;
    logic [OP_W-1:0]      s1_op_reg;
    logic [ADDR_W-1:0]    s1_addr_reg;
    logic [LINE_W-1:0]    s1_sel_reg;
    logic                 s1_sel_ok_reg;
    logic                 s1_rd_ok_reg;
    logic                 s1_fill_ok_reg;
    logic [DATA_W-1:0]    rd_data_reg;

    logic [ADDR_W-1:0]    tag_reg [LINES];
    logic [ADDR_W-1:0]    tag_next [LINES];
    logic [LINES-1:0]     valid_reg, valid_next;
    logic [LINE_W-1:0]    ptr_reg, ptr_next;

    logic                 out_valid_reg, out_valid_next;
    logic                 hit_reg, hit_next;
    logic [IDX_W-1:0]     line_index_reg, line_index_next;
    logic [DATA_W-1:0]    read_byte_reg, read_byte_next;

    logic                 out_free;
    logic                 accept;
    logic                 advance;
    logic [31:0]          sel_ext;
    logic [31:0]          off_ext;
    logic                 sel_ok;
    logic                 off_ok;
    logic [MEM_AW-1:0]    mem_addr;
    logic                 mem_we;
    logic [LINES-1:0]     match;
    logic                 found;
    logic [LINE_W-1:0]    hit_idx;

    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = s1_valid_reg && !out_free;
    assign accept   = in_valid && !in_stall;
    assign advance  = s1_valid_reg && out_free;

    assign sel_ext  = 32'(line_select);
    assign off_ext  = 32'(byte_offset);
    assign sel_ok   = sel_ext < 32'(LINES);
    assign off_ok   = off_ext < 32'(BLOCK_BYTES);
    assign mem_addr = {sel_ext[LINE_W-1:0], off_ext[OFF_W-1:0]};
    assign mem_we   = accept && (operation == OP_FILL_BYTE) && sel_ok && off_ok;

    // sector ram, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            sector_mem[mem_addr] <= fill_byte;
        end
        if (accept)
        begin
            rd_data_reg <= sector_mem[mem_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_op_reg      <= operation;
            s1_addr_reg    <= block_address;
            s1_sel_reg     <= sel_ext[LINE_W-1:0];
            s1_sel_ok_reg  <= sel_ok;
            s1_rd_ok_reg   <= sel_ok && off_ok;
            s1_fill_ok_reg <= fill_ok;
        end
    end

    // tag compare, lowest matching line wins
    always_comb
    begin
        found   = 1'b0;
        hit_idx = '0;
        for (int i = 0; i < LINES; i++)
        begin
            match[i] = valid_reg[i] && (tag_reg[i] == s1_addr_reg);
        end
        for (int i = LINES - 1; i >= 0; i--)
        begin
            if (match[i])
            begin
                found   = 1'b1;
                hit_idx = LINE_W'(i);
            end
        end
    end

    always_comb
    begin
        s1_valid_next   = s1_valid_reg;
        out_valid_next  = out_valid_reg;
        hit_next        = hit_reg;
        line_index_next = line_index_reg;
        read_byte_next  = read_byte_reg;
        tag_next        = tag_reg;
        valid_next      = valid_reg;
        ptr_next        = ptr_reg;

        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (out_free)
        begin
            s1_valid_next = 1'b0;
        end

        if (out_free)
        begin
            out_valid_next = s1_valid_reg;
        end

        if (advance)
        begin
            hit_next        = 1'b0;
            line_index_next = '0;
            read_byte_next  = '0;
            case (s1_op_reg)
                OP_LOOKUP:
                begin
                    if (found)
                    begin
                        hit_next        = 1'b1;
                        line_index_next = IDX_W'(hit_idx);
                    end
                    else
                    begin
                        tag_next[ptr_reg]   = s1_addr_reg;
                        valid_next[ptr_reg] = 1'b0;
                        line_index_next     = IDX_W'(ptr_reg);
                        ptr_next = (ptr_reg == LINE_W'(LINES - 1)) ? '0 : ptr_reg + 1'b1;
                    end
                end
                OP_FILL_DONE:
                begin
                    if (s1_sel_ok_reg)
                    begin
                        valid_next[s1_sel_reg] = s1_fill_ok_reg;
                    end
                end
                OP_READ_BYTE:
                begin
                    if (s1_rd_ok_reg)
                    begin
                        read_byte_next = rd_data_reg;
                    end
                end
                OP_INVALIDATE:
                begin
                    for (int i = 0; i < LINES; i++)
                    begin
                        tag_next[i] = '0;
                    end
                    valid_next = '0;
                    ptr_next   = '0;
                end
                default:
                begin
                    ptr_next = ptr_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            valid_reg     <= '0;
            ptr_reg       <= '0;
            for (int i = 0; i < LINES; i++)
            begin
                tag_reg[i] <= '0;
            end
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            valid_reg     <= valid_next;
            ptr_reg       <= ptr_next;
            tag_reg       <= tag_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hit_reg        <= hit_next;
        line_index_reg <= line_index_next;
        read_byte_reg  <= read_byte_next;
    end

    assign out_valid  = out_valid_reg;
    assign hit        = hit_reg;
    assign line_index = line_index_reg;
    assign read_byte  = read_byte_reg;

endmodule

### hw/rtl/scfr_checker.sv
`include "sector_cache_fifo_replace_core_macros.svh"

module scfr_checker
    import scfr_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                in_stall,
    input logic                out_valid,
    input logic                out_stall,
    input logic                hit,
    input logic [IDX_W-1:0]    line_index,
    input logic [DATA_W-1:0]   read_byte
);

    // stalled result holds
    `SCFR_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall,
        out_valid && $stable(hit) && $stable(line_index) && $stable(read_byte))

    // an empty output side never pushes back
    `SCFR_ASSERT_NOW(a_no_stall_when_empty, clk, rst_n, !out_valid, !in_stall)

    // a hit is a lookup result, so no read data rides along
    `SCFR_ASSERT_NOW(a_hit_no_data, clk, rst_n, out_valid && hit, read_byte == '0)

    // a nonzero line index only comes from a lookup
    `SCFR_ASSERT_NOW(a_index_no_data, clk, rst_n, out_valid && (line_index != '0),
        read_byte == '0)

endmodule

bind sector_cache_fifo_replace_core scfr_checker u_scfr_checker (.*);

### tb/sv/sector_cache_fifo_replace_core_test.sv
`timescale 1ns / 100ps

module sector_cache_fifo_replace_core_test;

    import scfr_pkg::*;

    localparam int LINES        = LINES_DEF;
    localparam int BLOCK_BYTES  = BLOCK_BYTES_DEF;
    localparam int RANDOM_ITEMS = 1050;
    localparam int HOLD_AT      = 300;
    localparam int HOLD_CYCLES  = 200;
    localparam int DRAIN_CYCLES = 10;
    localparam int CYCLE_LIMIT  = 100000;

    // codes the block leaves unused
    localparam logic [OP_W-1:0] OP_UNUSED_LO = 3'd5;
    localparam logic [OP_W-1:0] OP_UNUSED_HI = 3'd7;

    typedef struct packed {
        logic [OP_W-1:0]     op;
        logic [ADDR_W-1:0]   addr;
        logic [SEL_W-1:0]    sel;
        logic [OFFSET_W-1:0] offset;
        logic [DATA_W-1:0]   data;
        logic                ok;
    } cache_req_t;

    typedef struct packed {
        logic              hit;
        logic [IDX_W-1:0]  line;
        logic [DATA_W-1:0] rbyte;
    } cache_resp_t;

    typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_ALTERNATE} stall_mode_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic [OP_W-1:0]     operation = '0;
    logic [ADDR_W-1:0]   block_address = '0;
    logic [SEL_W-1:0]    line_select = '0;
    logic [OFFSET_W-1:0] byte_offset = '0;
    logic [DATA_W-1:0]   fill_byte = '0;
    logic                fill_ok = 1'b0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic                hit;
    logic [IDX_W-1:0]    line_index;
    logic [DATA_W-1:0]   read_byte;

    // predicted cache contents
    logic [ADDR_W-1:0] tag_copy [LINES] = '{default: '0};
    logic              valid_copy [LINES] = '{default: 1'b0};
    int                fifo_ptr = 0;
    logic [DATA_W-1:0] sector_copy [LINES*BLOCK_BYTES];

    // bytes already filled, as seen while building requests
    bit                byte_filled [LINES*BLOCK_BYTES];
    int                filled_slots [$];
    logic [ADDR_W-1:0] tag_pool [6];

    cache_req_t  queued_requests [$];
    cache_resp_t responses_due [$];
    cache_req_t  staged_req;
    cache_resp_t due_resp;

    int          total_items = 0;
    int          accepted_total = 0;
    int          checked_total = 0;
    int          error_count = 0;
    int          cycle_count = 0;
    int          gap_left = 0;
    int          burst_left = 1;
    int          hold_left = 0;
    bit          hold_done = 1'b0;
    int          phase_left = 0;
    stall_mode_t stall_mode = STALL_NONE;

    sector_cache_fifo_replace_core #(
        .LINES       (LINES),
        .BLOCK_BYTES (BLOCK_BYTES)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .operation     (operation),
        .block_address (block_address),
        .line_select   (line_select),
        .byte_offset   (byte_offset),
        .fill_byte     (fill_byte),
        .fill_ok       (fill_ok),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .hit           (hit),
        .line_index    (line_index),
        .read_byte     (read_byte)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic log_mismatch(input string msg);
        $display("mismatch at response %0d: %s", checked_total, msg);
        error_count++;
    endtask

    function automatic cache_resp_t predict_cache_response(input cache_req_t r);
        cache_resp_t resp;
        logic        found;
        bit          sel_ok;
        bit          off_ok;
        resp   = '0;
        found  = 1'b0;
        sel_ok = int'(r.sel) < LINES;
        off_ok = int'(r.offset) < BLOCK_BYTES;
        case (r.op)
            OP_LOOKUP:
            begin
                for (int i = 0; i < LINES; i++)
                begin
                    if (!found && valid_copy[i] && tag_copy[i] == r.addr)
                    begin
                        found     = 1'b1;
                        resp.hit  = 1'b1;
                        resp.line = IDX_W'(i);
                    end
                end
                if (!found)
                begin
                    tag_copy[fifo_ptr]   = r.addr;
                    valid_copy[fifo_ptr] = 1'b0;
                    resp.line            = IDX_W'(fifo_ptr);
                    fifo_ptr             = (fifo_ptr + 1 >= LINES) ? 0 : fifo_ptr + 1;
                end
            end
            OP_FILL_BYTE:
            begin
                if (sel_ok && off_ok)
                    sector_copy[int'(r.sel) * BLOCK_BYTES + int'(r.offset)] = r.data;
            end
            OP_FILL_DONE:
            begin
                if (sel_ok)
                    valid_copy[r.sel] = r.ok;
            end
            OP_READ_BYTE:
            begin
                if (sel_ok && off_ok)
                    resp.rbyte = sector_copy[int'(r.sel) * BLOCK_BYTES + int'(r.offset)];
            end
            OP_INVALIDATE:
            begin
                for (int i = 0; i < LINES; i++)
                begin
                    tag_copy[i]   = '0;
                    valid_copy[i] = 1'b0;
                end
                fifo_ptr = 0;
            end
            default:
            begin
            end
        endcase
        return resp;
    endfunction

    function automatic void queue_op(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] addr,
                                     input logic [SEL_W-1:0] sel,
                                     input logic [OFFSET_W-1:0] offset,
                                     input logic [DATA_W-1:0] data, input logic ok);
        int slot;
        slot = int'(sel) * BLOCK_BYTES + int'(offset);
        if (op == OP_FILL_BYTE && int'(sel) < LINES && int'(offset) < BLOCK_BYTES
            && !byte_filled[slot])
        begin
            byte_filled[slot] = 1'b1;
            filled_slots.push_back(slot);
        end
        queued_requests.push_back('{op: op, addr: addr, sel: sel, offset: offset,
                                    data: data, ok: ok});
    endfunction

    function automatic void queue_read_of_filled();
        int slot;
        slot = filled_slots[$urandom_range(0, filled_slots.size() - 1)];
        queue_op(OP_READ_BYTE, $urandom(), SEL_W'(slot / BLOCK_BYTES),
                 OFFSET_W'(slot % BLOCK_BYTES), DATA_W'($urandom()), 1'($urandom()));
    endfunction

    function automatic logic [ADDR_W-1:0] pick_block_address();
        if ($urandom_range(0, 3) == 0)
            return $urandom();
        return tag_pool[$urandom_range(0, 5)];
    endfunction

    initial
    begin
        logic [ADDR_W-1:0] seq_addr;
        logic [SEL_W-1:0]  seq_line;
        int                pick;
        tag_pool[0] = '0;
        tag_pool[1] = '1;
        for (int i = 2; i < 6; i++)
            tag_pool[i] = $urandom();

        // allocation from reset, zero tags stay invalid
        queue_op(OP_LOOKUP, 32'h0000_0000, 2'd0, 9'd0, 8'h00, 1'b0);
        queue_op(OP_LOOKUP, 32'hFFFF_FFFF, 2'd3, 9'd511, 8'hFF, 1'b1);
        queue_op(OP_FILL_BYTE, 32'h0, 2'd0, 9'd0, 8'hFF, 1'b0);
        queue_op(OP_FILL_BYTE, 32'h0, 2'd3, 9'd511, 8'h00, 1'b1);
        queue_op(OP_FILL_BYTE, 32'h0, 2'd1, 9'd256, 8'hA5, 1'b0);
        queue_op(OP_FILL_DONE, 32'h0, 2'd0, 9'd0, 8'h00, 1'b1);
        queue_op(OP_FILL_DONE, 32'h0, 2'd1, 9'd0, 8'h00, 1'b0);
        queue_op(OP_LOOKUP, 32'h0000_0000, 2'd0, 9'd0, 8'h00, 1'b0);
        // two lines with the same tag, lowest wins
        queue_op(OP_LOOKUP, 32'hFFFF_FFFF, 2'd0, 9'd0, 8'h00, 1'b0);
        queue_op(OP_FILL_DONE, 32'h0, 2'd2, 9'd0, 8'h00, 1'b1);
        queue_op(OP_FILL_DONE, 32'h0, 2'd1, 9'd0, 8'h00, 1'b1);
        queue_op(OP_LOOKUP, 32'hFFFF_FFFF, 2'd0, 9'd0, 8'h00, 1'b0);
        queue_op(OP_READ_BYTE, 32'h0, 2'd0, 9'd0, 8'h00, 1'b0);
        queue_op(OP_READ_BYTE, 32'h0, 2'd3, 9'd511, 8'h00, 1'b0);
        queue_op(OP_READ_BYTE, 32'h0, 2'd1, 9'd256, 8'h00, 1'b0);
        for (int op = int'(OP_UNUSED_LO); op <= int'(OP_UNUSED_HI); op++)
            queue_op(OP_W'(op), '1, 2'd3, 9'd511, 8'hFF, 1'b1);
        // pointer wraps around
        queue_op(OP_LOOKUP, 32'h1234_5678, 2'd0, 9'd0, 8'h00, 1'b0);
        queue_op(OP_LOOKUP, 32'h8765_4321, 2'd0, 9'd0, 8'h00, 1'b0);
        queue_op(OP_INVALIDATE, 32'h0, 2'd0, 9'd0, 8'h00, 1'b0);
        queue_op(OP_LOOKUP, 32'h0000_0000, 2'd0, 9'd0, 8'h00, 1'b0);
        queue_op(OP_READ_BYTE, 32'h0, 2'd0, 9'd0, 8'h00, 1'b0);
        // line made valid without a miss, keeps its cleared tag
        queue_op(OP_FILL_DONE, 32'h0, 2'd3, 9'd0, 8'h00, 1'b1);
        queue_op(OP_LOOKUP, 32'h0000_0000, 2'd0, 9'd0, 8'h00, 1'b0);

        total_items = queued_requests.size() + RANDOM_ITEMS;
        while (queued_requests.size() < total_items)
        begin
            if ($urandom_range(0, 9) < 6)
            begin
                // lookup, fill a random line, close it and look again
                seq_addr = pick_block_address();
                seq_line = SEL_W'($urandom());
                queue_op(OP_LOOKUP, seq_addr, SEL_W'($urandom()), OFFSET_W'($urandom()),
                         DATA_W'($urandom()), 1'($urandom()));
                repeat ($urandom_range(1, 4))
                    queue_op(OP_FILL_BYTE, $urandom(), seq_line, OFFSET_W'($urandom()),
                             DATA_W'($urandom()), 1'($urandom()));
                queue_op(OP_FILL_DONE, $urandom(), seq_line, OFFSET_W'($urandom()),
                         DATA_W'($urandom()), $urandom_range(0, 7) != 0);
                queue_op(OP_LOOKUP, seq_addr, SEL_W'($urandom()), OFFSET_W'($urandom()),
                         DATA_W'($urandom()), 1'($urandom()));
                repeat ($urandom_range(0, 2))
                    queue_read_of_filled();
            end
            else
            begin
                pick = $urandom_range(0, 19);
                if (pick < 6)
                    queue_op(OP_LOOKUP, pick_block_address(), SEL_W'($urandom()),
                             OFFSET_W'($urandom()), DATA_W'($urandom()), 1'($urandom()));
                else if (pick < 11)
                    queue_op(OP_FILL_BYTE, $urandom(), SEL_W'($urandom()),
                             OFFSET_W'($urandom()), DATA_W'($urandom()), 1'($urandom()));
                else if (pick < 14)
                    queue_op(OP_FILL_DONE, $urandom(), SEL_W'($urandom()),
                             OFFSET_W'($urandom()), DATA_W'($urandom()), 1'($urandom()));
                else if (pick < 18)
                    queue_read_of_filled();
                else if (pick < 19)
                    queue_op(OP_INVALIDATE, $urandom(), SEL_W'($urandom()),
                             OFFSET_W'($urandom()), DATA_W'($urandom()), 1'($urandom()));
                else
                    queue_op(OP_W'($urandom_range(32'(OP_UNUSED_LO), 32'(OP_UNUSED_HI))),
                             $urandom(), SEL_W'($urandom()), OFFSET_W'($urandom()),
                             DATA_W'($urandom()), 1'($urandom()));
            end
        end
        total_items = queued_requests.size();

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (accepted_total != total_items || responses_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (responses_due.size() != 0)
            log_mismatch($sformatf("%0d responses never arrived", responses_due.size()));
        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // request driver: bursts with random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                responses_due.push_back(predict_cache_response(
                    '{op: operation, addr: block_address, sel: line_select,
                      offset: byte_offset, data: fill_byte, ok: fill_ok}));
                accepted_total <= accepted_total + 1;
            end
            if (!in_valid || !in_stall)
            begin
                if (gap_left != 0)
                begin
                    in_valid <= 1'b0;
                    gap_left <= gap_left - 1;
                end
                else if (queued_requests.size() != 0)
                begin
                    staged_req = queued_requests.pop_front();
                    in_valid      <= 1'b1;
                    operation     <= staged_req.op;
                    block_address <= staged_req.addr;
                    line_select   <= staged_req.sel;
                    byte_offset   <= staged_req.offset;
                    fill_byte     <= staged_req.data;
                    fill_ok       <= staged_req.ok;
                    if (burst_left <= 1)
                    begin
                        burst_left <= $urandom_range(1, 24);
                        gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end
                    else
                    begin
                        burst_left <= burst_left - 1;
                    end
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // response stall pattern with one long hold-off
    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (!hold_done && accepted_total >= HOLD_AT)
        begin
            out_stall <= 1'b1;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else
        begin
            if (phase_left == 0)
            begin
                stall_mode <= stall_mode_t'($urandom_range(0, 3));
                phase_left <= $urandom_range(10, 60);
            end
            else
            begin
                phase_left <= phase_left - 1;
            end
            case (stall_mode)
                STALL_NONE:      out_stall <= 1'b0;
                STALL_LIGHT:     out_stall <= ($urandom_range(0, 3) == 0);
                STALL_HEAVY:     out_stall <= ($urandom_range(0, 3) != 0);
                STALL_ALTERNATE: out_stall <= ~out_stall;
                default:         out_stall <= 1'b0;
            endcase
        end
    end

    // response checker
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (responses_due.size() == 0)
            begin
                log_mismatch($sformatf("unexpected response hit=%0b line=%0d byte=%02h",
                                       hit, line_index, read_byte));
            end
            else
            begin
                due_resp = responses_due.pop_front();
                if (hit !== due_resp.hit)
                    log_mismatch($sformatf("hit %0b, want %0b", hit, due_resp.hit));
                if (line_index !== due_resp.line)
                    log_mismatch($sformatf("line_index %0d, want %0d", line_index,
                                           due_resp.line));
                if (read_byte !== due_resp.rbyte)
                    log_mismatch($sformatf("read_byte %02h, want %02h", read_byte,
                                           due_resp.rbyte));
            end
            checked_total <= checked_total + 1;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Regression FAIL");
            $finish;
        end
    end

endmodule

### sector_cache_fifo_replace_core.f
+incdir+hw/rtl
hw/rtl/scfr_pkg.sv
hw/rtl/sector_cache_fifo_replace_core.sv
hw/rtl/scfr_checker.sv
tb/sv/sector_cache_fifo_replace_core_test.sv
